>>> rtl/linear_probe_hash_table_macros.svh
// Assertion macros for the hash table block
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH
// assert that a implies b at every clock edge, outside reset
`define LPHT_ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// assert that a implies b at the next clock edge, outside reset
`define LPHT_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

>>> rtl/lpht_pkg.sv
// Shared types and constants of the hash table
`timescale 1ns / 1ps
package lpht_pkg;
  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_GET = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_INVALID = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [63:0] HASH_SEED = 64'd5381;
  localparam logic [6:0] LOAD_LIMIT_RESET = 7'd75;

  // stored value width, at most the 32-bit value field
  localparam int VALUE_BITS = 32;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [31:0] value;
  } lpht_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] value_out;
    logic [1:0]  status;
  } lpht_out_t;
endpackage

>>> rtl/lpht_ram.sv
// Generic single-port-write, one-read RAM with registered read
`timescale 1ns / 1ps
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/lpht_hash.sv
// Byte-serial djb2 hash: one key byte per cycle
`timescale 1ns / 1ps
module lpht_hash
  import lpht_pkg::*;
#(
  parameter int KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] key,
  output logic        done,
  output logic [63:0] hash
);
  localparam int BW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES + 1) : 1;

  logic [63:0] h_r, h_nxt;
  logic [63:0] k_r, k_nxt;
  logic [BW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;

  always_comb begin
    h_nxt = h_r;
    k_nxt = k_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      h_nxt = HASH_SEED;
      k_nxt = key;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (k_r[7:0] == 8'd0 || cnt_r == BW'(KEY_BYTES)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        h_nxt = (h_r << 5) + h_r + {56'd0, k_r[7:0]};
        k_nxt = {8'd0, k_r[63:8]};
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    h_r <= h_nxt;
    k_r <= k_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign hash = h_r;
endmodule

>>> rtl/linear_probe_hash_table.sv
// Flow: the byte-serial hash takes the key bytes, then each probed slot is read and
// checked, and the result goes into the result register; a remove adds a cluster walk
// of up to TABLE_DEPTH-1 slots, each rehashed.
// One item is in work at a time; the byte-serial hash and the serial probe set the pace.
// The result sits in an output register, so a new item is taken while it waits.
// Synchronous reset clears occupancy flags (TABLE_DEPTH flip-flops) and count, and sets limit to LOAD_LIMIT_RESET.
`timescale 1ns / 1ps
module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lpht_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output lpht_out_t out_data,
  input  logic      cfg_we,
  input  logic [6:0] cfg_wdata
);
`include "linear_probe_hash_table_macros.svh"

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = 64 + VALUE_BITS;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_HASH    = 10'b0000000010,
    S_PREAD   = 10'b0000000100,
    S_PCHK    = 10'b0000001000,
    S_LOAD    = 10'b0000010000,
    S_BREAD   = 10'b0000100000,
    S_BHASHGO = 10'b0001000000,
    S_BHASH   = 10'b0010000000,
    S_BCHK    = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic [63:0] key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] hole_r, hole_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [6:0] limit_r;
  logic [TABLE_DEPTH-1:0] occ_r, occ_nxt;
  logic [EW-1:0] ent_r, ent_nxt;
  logic out_valid_r, out_valid_nxt;
  lpht_out_t out_r, out_nxt;
  lpht_out_t res_r, res_nxt;

  logic hash_start;
  logic [63:0] hash_key;
  logic hash_done;
  logic [63:0] hash_val;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic [63:0] clean_key;
  logic [6:0] pct;
  logic [AW-1:0] home, d_s, d_h;
  logic [AW-1:0] pos_inc;

  // drop bytes at and after the first zero byte, and bytes beyond KEY_BYTES
  always_comb begin
    logic stop;
    stop = 1'b0;
    clean_key = '0;
    for (int i = 0; i < 8; i++) begin
      if (i >= KEY_BYTES || in_data.key[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) clean_key[8*i +: 8] = in_data.key[8*i +: 8];
    end
  end

  lpht_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
    .clk(clk), .rst_n(rst_n), .start(hash_start), .key(hash_key),
    .done(hash_done), .hash(hash_val)
  );

  lpht_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign pos_inc = (32'(pos_r) == TABLE_DEPTH - 1) ? '0 : pos_r + 1'b1;
  assign home = hash_val[AW-1:0];
  assign d_s = pos_r - home;
  assign d_h = hole_r - home;
  // percentage after one more entry; count fits CW bits, product well under 2^24
  assign pct = 7'((24'(count_r) + 24'd1) * 24'd100 / 24'(TABLE_DEPTH) > 24'd127 ?
                  24'd127 : (24'(count_r) + 24'd1) * 24'd100 / 24'(TABLE_DEPTH));
  assign raddr = pos_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    key_nxt = key_r;
    val_nxt = val_r;
    pos_nxt = pos_r;
    hole_nxt = hole_r;
    steps_nxt = steps_r;
    count_nxt = count_r;
    occ_nxt = occ_r;
    ent_nxt = ent_r;
    out_nxt = out_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    hash_start = 1'b0;
    hash_key = key_r;
    we = 1'b0;
    waddr = pos_r;
    wdata = {key_r, val_r};
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_data.op;
          key_nxt = clean_key;
          val_nxt = in_data.value[VALUE_BITS-1:0];
          res_nxt = '0;
          if (in_data.op == OP_SET || in_data.op == OP_GET || in_data.op == OP_REMOVE) begin
            hash_start = 1'b1;
            hash_key = clean_key;
            state_nxt = S_HASH;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          pos_nxt = home;
          steps_nxt = '0;
          state_nxt = S_PREAD;
        end
      end
      S_PREAD: state_nxt = S_PCHK;
      S_PCHK: begin
        if (!occ_r[pos_r]) begin
          if (op_r == OP_SET && pct <= limit_r) begin
            we = 1'b1;
            occ_nxt[pos_r] = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            res_nxt.status = (op_r == OP_SET) ? ST_FULL : ST_NOT_FOUND;
          end
          state_nxt = S_OUT;
        end else if (rdata[EW-1 -: 64] == key_r) begin
          res_nxt.found = 1'b1;
          state_nxt = S_OUT;
          if (op_r == OP_SET) begin
            we = 1'b1;
          end else if (op_r == OP_GET) begin
            res_nxt.value_out = 32'(rdata[VALUE_BITS-1:0]);
          end else begin
            occ_nxt[pos_r] = 1'b0;
            count_nxt = count_r - 1'b1;
            hole_nxt = pos_r;
            pos_nxt = pos_inc;
            steps_nxt = CW'(1);
            state_nxt = S_BREAD;
          end
        end else if (32'(steps_r) == TABLE_DEPTH - 1) begin
          res_nxt.status = (op_r == OP_SET) ? ST_FULL : ST_NOT_FOUND;
          state_nxt = S_OUT;
        end else begin
          pos_nxt = pos_inc;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_PREAD;
        end
      end
      S_BREAD: begin
        if (32'(steps_r) == TABLE_DEPTH || !occ_r[pos_r]) state_nxt = S_OUT;
        else state_nxt = S_BHASHGO;
      end
      S_BHASHGO: begin
        ent_nxt = rdata;
        hash_start = 1'b1;
        hash_key = rdata[EW-1 -: 64];
        state_nxt = S_BHASH;
      end
      S_BHASH: if (hash_done) state_nxt = S_BCHK;
      S_BCHK: begin
        if (d_s > d_h) begin
          we = 1'b1;
          waddr = hole_r;
          wdata = ent_r;
          occ_nxt[hole_r] = 1'b1;
          occ_nxt[pos_r] = 1'b0;
          hole_nxt = pos_r;
        end
        pos_nxt = pos_inc;
        steps_nxt = steps_r + 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: state_nxt = S_BREAD; // read of new pos_r is issued here
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt = res_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      occ_r <= '0;
      limit_r <= LOAD_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      occ_r <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
    end
    op_r <= op_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
    pos_r <= pos_nxt;
    hole_r <= hole_nxt;
    steps_r <= steps_nxt;
    ent_r <= ent_nxt;
    out_r <= out_nxt;
    res_r <= res_nxt;
  end

  `LPHT_ASSERT_IMPLY(a_count_occ, clk, rst_n, 1'b1, 32'(count_r) == $countones(occ_r), "entry count disagrees with occupancy")
  `LPHT_ASSERT_IMPLY(a_idle_ready, clk, rst_n, state_r == S_IDLE, !in_stall, "idle block stalls input")
  `LPHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && out_stall, out_valid_r && $stable(out_r), "stalled result changed")
endmodule
